// ===== sv/vurpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vurpt_pkg - shared types and constants of the video register port
// Codes for stream items, register numbers, frame timing constants and the
// packed layouts of the input and result transfers.
// ----------------------------------------------------------------------------
package vurpt_pkg;

    // Stream widths
    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned S_TUSER_W = 5;
    localparam int unsigned M_TDATA_W = 40;

    // Item kinds carried in tuser
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_PEEK  = 2'd2;
    localparam logic [1:0] ACT_WRITE = 2'd3;

    // Register numbers in the eight-register window
    localparam logic [2:0] REG_CTRL   = 3'd0;
    localparam logic [2:0] REG_MASK   = 3'd1;
    localparam logic [2:0] REG_STATUS = 3'd2;
    localparam logic [2:0] REG_SPRADR = 3'd3;
    localparam logic [2:0] REG_SPRDAT = 3'd4;
    localparam logic [2:0] REG_SCROLL = 3'd5;
    localparam logic [2:0] REG_ADDR   = 3'd6;
    localparam logic [2:0] REG_DATA   = 3'd7;

    // Frame timing
    localparam logic [9:0] DOTS_PER_LINE   = 10'd341;
    localparam logic [8:0] VBLANK_LINE     = 9'd241;
    localparam logic [8:0] LINES_PER_FRAME = 9'd262;

    // Video address handling
    localparam logic [14:0] PALETTE_START = 15'h3F00;
    localparam logic [14:0] STEP_WIDE     = 15'd32;
    localparam logic [14:0] STEP_NARROW   = 15'd1;

    // Control register bits
    localparam int unsigned CTRL_STEP_BIT = 2;
    localparam int unsigned CTRL_NMI_BIT  = 7;

    // Input tdata, lowest field last in the declaration
    typedef struct packed {
        logic [7:0] vram_read_data;
        logic [7:0] tick_cycles;
        logic [7:0] write_data;
    } t_item;

    // Input tuser
    typedef struct packed {
        logic [2:0] reg_index;
        logic [1:0] action;
    } t_kind;

    // Result tdata
    typedef struct packed {
        logic [5:0]  pad;
        logic        frame_done;
        logic        nmi_pulse;
        logic [7:0]  mem_write_data;
        logic        mem_write_en;
        logic [14:0] mem_addr;
        logic [7:0]  read_data;
    } t_result;

endpackage

// ===== sv/video_unit_register_port_and_timing.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_unit_register_port_and_timing - processor register port and timing
// Eight-register window of a picture unit (control, mask, status, scroll,
// address, data) plus the dot / scanline / frame counters.
//
//   channel  dir  handshake                  payload
//   s        in   i_s_tvalid / o_s_tready    i_s_tdata, i_s_tuser
//   m        out  o_m_tvalid / i_m_tready    o_m_tdata
//
// One item is taken per cycle unless a stall on m backs up the input register.
// A transfer loads the input register; the result register loads from it when
// empty or taken, and o_m_tvalid is the result register's valid flag.
// All register state is updated as an item moves from the input register
// into the result register, so the next item already sees it.
// Reset clears all register state and both valid flags.
// A stall on m holds the result register; the input register still fills,
// then o_s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module video_unit_register_port_and_timing (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [7:0] write_data, [15:8] tick_cycles, [23:16] vram_read_data
    input  logic [vurpt_pkg::S_TDATA_W-1:0] i_s_tdata,
    // [1:0] action, [4:2] reg_index
    input  logic [vurpt_pkg::S_TUSER_W-1:0] i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [7:0] read_data, [22:8] mem_addr, [23] mem_write_en,
    // [31:24] mem_write_data, [32] nmi_pulse, [33] frame_done, [39:34] zero
    output logic [vurpt_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import vurpt_pkg::*;

    // Pipeline registers
    logic    r_in_valid;
    t_item   r_in_data;
    t_kind   r_in_kind;
    logic    r_out_valid;
    t_result r_out_data;

    // Architectural state (status keeps only its vblank bit; bits 6:5 read as
    // zero and a read fills bits 4:0 from the read buffer). Fine x scroll has no
    // visible use without rendering and is not kept.
    logic [7:0]  r_ctrl,   n_ctrl;
    logic [7:0]  r_mask,   n_mask;
    logic        r_vblank, n_vblank;
    logic [7:0]  r_rbuf,   n_rbuf;
    logic        r_toggle, n_toggle;
    logic [14:0] r_vaddr,  n_vaddr;
    logic [14:0] r_staged, n_staged;
    logic [9:0]  r_dot,    n_dot;
    logic [8:0]  r_line,   n_line;

    t_result     n_out;
    logic        w_out_adv;
    logic        w_in_adv;
    logic [10:0] w_dot_sum;
    logic [9:0]  w_dot_wrap;
    logic [8:0]  w_line_inc;
    logic [14:0] w_step;
    logic [14:0] w_vaddr_inc;
    logic [7:0]  w_status;

    // Handshake: result register moves when empty or taken
    assign w_out_adv  = !r_out_valid || i_m_tready;
    assign w_in_adv   = r_in_valid && w_out_adv;
    assign o_s_tready = !r_in_valid || w_out_adv;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // Shared arithmetic
    assign w_dot_sum   = {1'b0, r_dot} + {3'b000, r_in_data.tick_cycles};
    assign w_dot_wrap  = w_dot_sum[9:0];
    assign w_line_inc  = r_line + 9'd1;
    assign w_step      = r_ctrl[CTRL_STEP_BIT] ? STEP_WIDE : STEP_NARROW;
    assign w_vaddr_inc = r_vaddr + w_step;
    assign w_status    = {r_vblank, 7'b0000000};

    // Decode one item: result fields and next state
    always_comb begin
        n_ctrl   = r_ctrl;
        n_mask   = r_mask;
        n_vblank = r_vblank;
        n_rbuf   = r_rbuf;
        n_toggle = r_toggle;
        n_vaddr  = r_vaddr;
        n_staged = r_staged;
        n_dot    = r_dot;
        n_line   = r_line;
        n_out    = '0;

        case (r_in_kind.action)
            ACT_TICK: begin
                n_dot = w_dot_wrap;
                if (w_dot_wrap >= DOTS_PER_LINE) begin
                    n_dot  = w_dot_wrap - DOTS_PER_LINE;
                    n_line = w_line_inc;
                    if (w_line_inc == VBLANK_LINE) begin
                        n_vblank        = 1'b1;
                        n_out.nmi_pulse = r_ctrl[CTRL_NMI_BIT];
                    end
                    if (w_line_inc >= LINES_PER_FRAME) begin
                        n_vblank         = 1'b0;
                        n_line           = '0;
                        n_out.frame_done = 1'b1;
                    end
                end
            end
            ACT_READ: begin
                if (r_in_kind.reg_index == REG_STATUS) begin
                    n_out.read_data = {w_status[7:5], r_rbuf[4:0]};
                    n_vblank        = 1'b0;
                    n_toggle        = 1'b0;
                end else if (r_in_kind.reg_index == REG_DATA) begin
                    n_out.mem_addr  = r_vaddr;
                    n_rbuf          = r_in_data.vram_read_data;
                    n_out.read_data = (r_vaddr < PALETTE_START) ? r_rbuf
                                                                : r_in_data.vram_read_data;
                    n_vaddr         = w_vaddr_inc;
                end
            end
            ACT_PEEK: begin
                case (r_in_kind.reg_index)
                    REG_CTRL:   n_out.read_data = r_ctrl;
                    REG_MASK:   n_out.read_data = r_mask;
                    REG_STATUS: n_out.read_data = w_status;
                    default:    n_out.read_data = '0;
                endcase
            end
            ACT_WRITE: begin
                case (r_in_kind.reg_index)
                    REG_CTRL: begin
                        n_ctrl          = r_in_data.write_data;
                        n_staged[11:10] = r_in_data.write_data[1:0];
                    end
                    REG_MASK: begin
                        n_mask = r_in_data.write_data;
                    end
                    REG_SCROLL: begin
                        // First transfer: coarse x; second: coarse y and fine y
                        if (!r_toggle) begin
                            n_staged[4:0] = r_in_data.write_data[7:3];
                            n_toggle      = 1'b1;
                        end else begin
                            n_staged[9:5]   = r_in_data.write_data[7:3];
                            n_staged[14:12] = r_in_data.write_data[2:0];
                            n_toggle        = 1'b0;
                        end
                    end
                    REG_ADDR: begin
                        // First transfer: high six bits; second: low byte and load
                        if (!r_toggle) begin
                            n_staged[13:8] = r_in_data.write_data[5:0];
                            n_staged[14]   = 1'b0;
                            n_toggle       = 1'b1;
                        end else begin
                            n_staged[7:0] = r_in_data.write_data;
                            n_vaddr       = {r_staged[14:8], r_in_data.write_data};
                            n_toggle      = 1'b0;
                        end
                    end
                    REG_DATA: begin
                        n_out.mem_addr       = r_vaddr;
                        n_out.mem_write_en   = 1'b1;
                        n_out.mem_write_data = r_in_data.write_data;
                        n_vaddr              = w_vaddr_inc;
                    end
                    default: begin
                        // drop writes to the sprite and status registers
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // Input register: take a transfer whenever the slot frees up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_data <= t_item'(i_s_tdata);
            r_in_kind <= t_kind'(i_s_tuser);
        end
    end

    // Result register: load on advance, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_adv) begin
            r_out_data <= n_out;
        end
    end

    // Register state: commit as the item leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl   <= '0;
            r_mask   <= '0;
            r_vblank <= 1'b0;
            r_rbuf   <= '0;
            r_toggle <= 1'b0;
            r_vaddr  <= '0;
            r_staged <= '0;
            r_dot    <= '0;
            r_line   <= '0;
        end else if (w_in_adv) begin
            r_ctrl   <= n_ctrl;
            r_mask   <= n_mask;
            r_vblank <= n_vblank;
            r_rbuf   <= n_rbuf;
            r_toggle <= n_toggle;
            r_vaddr  <= n_vaddr;
            r_staged <= n_staged;
            r_dot    <= n_dot;
            r_line   <= n_line;
        end
    end

endmodule

// ===== sv/vurpt_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vurpt_check - port-level checks of the video register port
// Watches the result stream and flags results that the block can never
// produce, plus a held payload under back-pressure.
// ----------------------------------------------------------------------------
module vurpt_check (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_m_tvalid,
    input logic                             i_m_tready,
    input logic [vurpt_pkg::M_TDATA_W-1:0] i_m_tdata
);
    import vurpt_pkg::*;

    t_result w_res;
    assign w_res = t_result'(i_m_tdata);

    // Hold the payload while the result waits
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=> $stable(i_m_tdata))
        else $error("result payload changed while stalled");

    // Vblank start and frame wrap happen on different lines
    a_nmi_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> !(w_res.nmi_pulse && w_res.frame_done))
        else $error("nmi and frame done in one result");

    // A data write returns nothing and carries no timing event
    a_write_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && w_res.mem_write_en) |->
            (w_res.read_data == 8'h00 && !w_res.nmi_pulse && !w_res.frame_done))
        else $error("data write result carries other fields");

    // Nothing leaves right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result valid right after reset");

endmodule

bind video_unit_register_port_and_timing vurpt_check u_vurpt_check (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);
